// ===== rtl/core/bfpa_pkg.sv =====
package bfpa_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int ADDR_BITS  = 16;
    localparam int OWNER_BITS = 4;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // request / result field widths
    localparam int OP_W     = 2;
    localparam int ENTRY_W  = 4;
    localparam int FIELD_W  = 16;
    localparam int REQ_W    = 4;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_DEFINE  = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_TOO_BIG   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one table entry as seen on the read port
    typedef struct packed {
        logic [ADDR_BITS-1:0]  base;
        logic [ADDR_BITS-1:0]  size;
        logic                  taken;
        logic [OWNER_BITS-1:0] owner;
    } tbl_rd_t;

    // table update from the sequencer
    typedef struct packed {
        logic                  define_en;
        logic                  take_en;
        logic                  free_en;
        logic [IDX_W-1:0]      idx;
        logic [ADDR_BITS-1:0]  base;
        logic [ADDR_BITS-1:0]  size;
        logic [OWNER_BITS-1:0] owner;
    } tbl_wr_t;

endpackage

// ===== rtl/core/best_fit_partition_allocator.sv =====
// Channel  | Ports                     | Contents
// ---------+---------------------------+------------------------------------------
// request  | s_tvalid s_tready s_tdata | opcode in tuser, fields in tdata
//          | s_tuser                   |
// result   | m_tvalid m_tready m_tdata | status in tuser, chosen slot in tdata
//          | m_tuser                   |
//
// Allocate scans all NUM_SLOTS slots through one compare unit, one slot per cycle;
// the finish state then writes the result once the output register is free.
// Release stops at the first owned slot; define and unused opcodes skip the scan
// and go straight to the finish state.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, so the next request is accepted while m_tready is low.
// Synchronous active-low reset frees all slots and clears base and size to zero.
module best_fit_partition_allocator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] entry_index, [19:4] base_address, [35:20] amount, [39:36] requester
    input  logic [bfpa_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] opcode
    input  logic [bfpa_pkg::OP_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] chosen_index, [19:4] chosen_base, [35:20] chosen_size, [39:36] zero
    output logic [bfpa_pkg::M_DATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [bfpa_pkg::STATUS_W-1:0]   m_tuser
);
    import bfpa_pkg::*;

    logic [IDX_W-1:0]   rd_idx;
    tbl_rd_t            rd;
    tbl_wr_t            wr;
    logic [ENTRY_W-1:0] res_index;
    logic [FIELD_W-1:0] res_base;
    logic [FIELD_W-1:0] res_size;

    bfpa_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (rd_idx),
        .rd      (rd),
        .wr      (wr)
    );

    bfpa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser),
        .req_entry  (s_tdata[3:0]),
        .req_base   (s_tdata[19:4]),
        .req_amount (s_tdata[35:20]),
        .req_who    (s_tdata[39:36]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (m_tuser),
        .res_index  (res_index),
        .res_base   (res_base),
        .res_size   (res_size),
        .rd_idx     (rd_idx),
        .rd         (rd),
        .wr         (wr)
    );

    assign m_tdata = {4'b0000, res_size, res_base, res_index};

endmodule

// ===== rtl/core/bfpa_table.sv =====
module bfpa_table (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [bfpa_pkg::IDX_W-1:0] rd_idx,
    output bfpa_pkg::tbl_rd_t       rd,
    input  bfpa_pkg::tbl_wr_t       wr
);
    import bfpa_pkg::*;

    logic [ADDR_BITS-1:0]  base_reg  [NUM_SLOTS];
    logic [ADDR_BITS-1:0]  size_reg  [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  taken_reg;
    logic [OWNER_BITS-1:0] owner_reg [NUM_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                base_reg[i] <= '0;
                size_reg[i] <= '0;
            end
            taken_reg <= '0;
        end else begin
            if (wr.define_en) begin
                base_reg[wr.idx]  <= wr.base;
                size_reg[wr.idx]  <= wr.size;
                taken_reg[wr.idx] <= 1'b0;
            end
            if (wr.take_en) begin
                taken_reg[wr.idx] <= 1'b1;
            end
            if (wr.free_en) begin
                taken_reg[wr.idx] <= 1'b0;
            end
        end
    end

    // owner is only read behind a set taken bit, so it needs no reset
    always_ff @(posedge aclk) begin
        if (wr.take_en) begin
            owner_reg[wr.idx] <= wr.owner;
        end
    end

    always_comb begin
        rd.base  = base_reg[rd_idx];
        rd.size  = size_reg[rd_idx];
        rd.taken = taken_reg[rd_idx];
        rd.owner = owner_reg[rd_idx];
    end

endmodule

// ===== rtl/core/bfpa_ctrl.sv =====
module bfpa_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [bfpa_pkg::OP_W-1:0]     req_op,
    input  logic [bfpa_pkg::ENTRY_W-1:0]  req_entry,
    input  logic [bfpa_pkg::FIELD_W-1:0]  req_base,
    input  logic [bfpa_pkg::FIELD_W-1:0]  req_amount,
    input  logic [bfpa_pkg::REQ_W-1:0]    req_who,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [bfpa_pkg::STATUS_W-1:0] res_status,
    output logic [bfpa_pkg::ENTRY_W-1:0]  res_index,
    output logic [bfpa_pkg::FIELD_W-1:0]  res_base,
    output logic [bfpa_pkg::FIELD_W-1:0]  res_size,
    output logic [bfpa_pkg::IDX_W-1:0]    rd_idx,
    input  bfpa_pkg::tbl_rd_t             rd,
    output bfpa_pkg::tbl_wr_t             wr
);
    import bfpa_pkg::*;

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [ENTRY_W-1:0]    entry_reg, entry_next;
    logic [ADDR_BITS-1:0]  base_reg, base_next;
    logic [ADDR_BITS-1:0]  amount_reg, amount_next;
    logic [OWNER_BITS-1:0] who_reg, who_next;
    logic [IDX_W-1:0]      scan_reg, scan_next;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [ADDR_BITS-1:0]  best_size_reg, best_size_next;
    logic                  found_reg, found_next;
    logic                  fit_reg, fit_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ENTRY_W-1:0]    out_index_reg, out_index_next;
    logic [FIELD_W-1:0]    out_base_reg, out_base_next;
    logic [FIELD_W-1:0]    out_size_reg, out_size_next;

    logic                  last_slot;
    logic                  fits;
    logic                  better;
    logic                  owner_hit;
    logic                  out_free;
    logic                  entry_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        entry_reg      <= entry_next;
        base_reg       <= base_next;
        amount_reg     <= amount_next;
        who_reg        <= who_next;
        scan_reg       <= scan_next;
        best_reg       <= best_next;
        best_size_reg  <= best_size_next;
        found_reg      <= found_next;
        fit_reg        <= fit_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_base_reg   <= out_base_next;
        out_size_reg   <= out_size_next;
    end

    // shared compare unit: one slot per cycle
    assign last_slot = (scan_reg == IDX_W'(NUM_SLOTS - 1));
    assign fits      = (rd.size >= amount_reg);
    assign better    = !rd.taken && fits && (!found_reg || (rd.size < best_size_reg));
    assign owner_hit = rd.taken && (rd.owner == who_reg);
    assign out_free  = !out_valid_reg || res_ready;
    assign entry_ok  = (32'(entry_reg) < 32'(NUM_SLOTS));
    assign rd_idx    = (state_reg == ST_FINISH) ? best_reg : scan_reg;

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        entry_next      = entry_reg;
        base_next       = base_reg;
        amount_next     = amount_reg;
        who_next        = who_reg;
        scan_next       = scan_reg;
        best_next       = best_reg;
        best_size_next  = best_size_reg;
        found_next      = found_reg;
        fit_next        = fit_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_base_next   = out_base_reg;
        out_size_next   = out_size_reg;
        req_ready       = 1'b0;

        wr           = '0;
        wr.idx       = best_reg;
        wr.owner     = who_reg;
        wr.base      = base_reg;
        wr.size      = amount_reg;

        case (state_reg)
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next     = req_op;
                    entry_next  = req_entry;
                    base_next   = ADDR_BITS'(req_base);
                    amount_next = ADDR_BITS'(req_amount);
                    who_next    = OWNER_BITS'(req_who);
                    scan_next   = '0;
                    best_next   = '0;
                    found_next  = 1'b0;
                    fit_next    = 1'b0;
                    if (req_op == OP_ALLOC || req_op == OP_RELEASE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (op_reg == OP_ALLOC) begin
                    fit_next = fit_reg || fits;
                    if (better) begin
                        found_next     = 1'b1;
                        best_next      = scan_reg;
                        best_size_next = rd.size;
                    end
                    if (last_slot) begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    // release stops at the first owned slot
                    if (owner_hit) begin
                        found_next = 1'b1;
                        best_next  = scan_reg;
                        state_next = ST_FINISH;
                    end else if (last_slot) begin
                        state_next = ST_FINISH;
                    end
                end
                scan_next = scan_reg + 1'b1;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_index_next  = '0;
                    out_base_next   = '0;
                    out_size_next   = '0;
                    case (op_reg)
                        OP_DEFINE: begin
                            if (entry_ok) begin
                                wr.define_en   = 1'b1;
                                wr.idx         = IDX_W'(entry_reg);
                                out_index_next = entry_reg;
                                out_base_next  = FIELD_W'(base_reg);
                                out_size_next  = FIELD_W'(amount_reg);
                            end
                        end
                        OP_ALLOC: begin
                            if (!fit_reg) begin
                                out_status_next = STAT_TOO_BIG;
                            end else if (!found_reg) begin
                                out_status_next = STAT_FULL;
                            end else begin
                                wr.take_en     = 1'b1;
                                out_index_next = ENTRY_W'(best_reg);
                                out_base_next  = FIELD_W'(rd.base);
                                out_size_next  = FIELD_W'(rd.size);
                            end
                        end
                        OP_RELEASE: begin
                            if (found_reg) begin
                                wr.free_en     = 1'b1;
                                out_index_next = ENTRY_W'(best_reg);
                                out_base_next  = FIELD_W'(rd.base);
                                out_size_next  = FIELD_W'(rd.size);
                            end else begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_index  = out_index_reg;
    assign res_base   = out_base_reg;
    assign res_size   = out_size_reg;

endmodule

// ===== rtl/core/bfpa_checker.sv =====
module bfpa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [bfpa_pkg::S_DATA_W-1:0]   s_tdata,
    input logic [bfpa_pkg::OP_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bfpa_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [bfpa_pkg::STATUS_W-1:0]   m_tuser
);
    import bfpa_pkg::*;

    // come out of reset idle with no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("not idle after reset");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while busy");

    // failures carry an all-zero slot
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("failed result with nonzero slot");

    // hold a stalled result
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind best_fit_partition_allocator bfpa_checker u_checker (.*);
